// ----- rtl/core/base64_stream_codec_macros.svh -----
// Assertion macros shared by the Base64 stream codec.
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64SC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("b64sc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64SC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("b64sc assertion failed");

`endif

// ----- rtl/core/b64sc_pkg.sv -----
// Types, constants and alphabet functions of the Base64 stream codec.
package b64sc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned ADDR_W      = 3;

	localparam logic        REG_MODE    = 1'b0;
	localparam logic        MODE_ENCODE = 1'b0;
	localparam logic        MODE_DECODE = 1'b1;

	localparam logic [7:0]  PAD_CHAR    = 8'h3D;
	localparam logic [7:0]  PLUS_CHAR   = 8'h2B;
	localparam logic [7:0]  SLASH_CHAR  = 8'h2F;
	localparam logic [6:0]  NO_CODE     = 7'd64;

	// One job: the results caused by one input item, emitted from byte 0 up.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            has_data;
		logic            last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)      return w + 8'h41;
		else if (v < 6'd52) return w + 8'h47;
		else if (v < 6'd62) return w - 8'h04;
		else if (v == 6'd62) return PLUS_CHAR;
		else                return SLASH_CHAR;
	endfunction

	function automatic logic [6:0] code_of(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h47);
		else if (c >= 8'h30 && c <= 8'h39) return 7'(c + 8'h04);
		else if (c == PLUS_CHAR)           return 7'd62;
		else if (c == SLASH_CHAR)          return 7'd63;
		else                               return NO_CODE;
	endfunction

endpackage

// ----- rtl/core/base64_stream_codec.sv -----
// Top level of the streaming Base64 codec: register port, front, queue and back.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   data_byte, last_item
//   output    out        out_valid / out_stall out_byte, has_data, run_end, message_end
//   config    in         APB write/read        mode (address 0)
//
// An input item is accepted in every cycle while the job queue has room, so a
// message streams in at one item per cycle. Results leave at one per cycle while
// the output is not stalled, through the output register, so encoding sustains
// four characters for every three bytes; with the back end idle the first result
// of an item passes the job queue, the current-job register and the output register
// before it is presented. Reset clears the mode register, the group state, the
// queue and the output stage at once; there is no clearing pass. A stalled output
// holds its result while the queue absorbs further items until it fills.
`include "base64_stream_codec_macros.svh"

module base64_stream_codec #(
	parameter int unsigned QueueDepth = b64sc_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [b64sc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        last_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        has_data,
	output logic                        run_end,
	output logic                        message_end
);

	logic                  mode_q;
	logic                  cfg_wr;
	logic                  push;
	logic                  pop;
	b64sc_pkg::job_t       push_job;
	b64sc_pkg::job_t       pop_job;
	b64sc_pkg::fifo_stat_t q_stat;

	// The only register sits at index 0; bit 2 of the byte address selects the
	// register index, so writes with bit 2 set are dropped. Writing the mode also
	// aborts any message in progress by clearing the group state.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == b64sc_pkg::REG_MODE);
	assign prdata = (paddr[2] == b64sc_pkg::REG_MODE) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= b64sc_pkg::MODE_ENCODE;
		end else if (cfg_wr) begin
			mode_q <= pwdata[0];
		end
	end

	// The front end turns each accepted transfer into a job holding every result
	// that the item causes; items that complete nothing are not queued.
	b64sc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.cfg_clear (cfg_wr),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.last_item (last_item),
		.q_stat    (q_stat),
		.in_stall  (in_stall),
		.push      (push),
		.job       (push_job)
	);

	b64sc_fifo #(
		.DEPTH (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.stat      (q_stat)
	);

	// The back end walks through a job one result per cycle unless the output stalls, and
	// marks the last result of the item, and of the message where the item was the last one.
	b64sc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_data    (pop_job),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.has_data    (has_data),
		.run_end     (run_end),
		.message_end (message_end)
	);

	// A bare end marker closes both the item and the message and carries no byte.
	`B64SC_ASSERT_IMP(a_end_marker, clk, arst_n, out_valid && !has_data, run_end && message_end && out_byte == 8'h00)
	// The end of a message is always the end of the item that caused it.
	`B64SC_ASSERT_IMP(a_msg_end_run_end, clk, arst_n, out_valid && message_end, run_end)
	// A mode write lands in the register on the edge of its transfer.
	`B64SC_ASSERT_NXT(a_mode_written, clk, arst_n, cfg_wr, mode_q == $past(pwdata[0]))

endmodule

// ----- rtl/core/b64sc_front.sv -----
// Front end: accepts items, keeps the group state and builds a job for each item that yields results.
module b64sc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mode,
	input  logic                 cfg_clear,
	input  logic                 in_valid,
	input  logic [7:0]           data_byte,
	input  logic                 last_item,
	input  b64sc_pkg::fifo_stat_t q_stat,
	output logic                 in_stall,
	output logic                 push,
	output b64sc_pkg::job_t      job
);

	logic [23:0] buf_q;
	logic [1:0]  cnt_q;
	logic        stop_q;

	logic [23:0] nxt_buf;
	logic [1:0]  nxt_cnt;
	logic        nxt_stop;
	logic [2:0]  n;
	logic [2:0]  cnt_e;
	logic [23:0] buf_e;
	logic [23:0] full_e;
	logic [23:0] dbuf;
	logic [1:0]  dcnt;
	logic [6:0]  code;
	logic        accept;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign push     = accept && (n != 3'd0);

	always_comb begin
		nxt_buf  = buf_q;
		nxt_cnt  = cnt_q;
		nxt_stop = stop_q;
		n        = 3'd0;
		job      = '0;
		cnt_e    = {1'b0, cnt_q} + 3'd1;
		buf_e    = {buf_q[15:0], data_byte};
		full_e   = '0;
		dbuf     = buf_q;
		dcnt     = cnt_q;
		code     = b64sc_pkg::code_of(data_byte);
		if (mode == b64sc_pkg::MODE_ENCODE) begin
			if (cnt_e == 3'd3) begin
				job.bytes[0] = b64sc_pkg::enc_char(buf_e[23:18]);
				job.bytes[1] = b64sc_pkg::enc_char(buf_e[17:12]);
				job.bytes[2] = b64sc_pkg::enc_char(buf_e[11:6]);
				job.bytes[3] = b64sc_pkg::enc_char(buf_e[5:0]);
				n       = 3'd4;
				nxt_buf = '0;
				nxt_cnt = 2'd0;
			end else begin
				nxt_buf = buf_e;
				nxt_cnt = cnt_e[1:0];
				if (last_item) begin
					full_e = (cnt_e == 3'd1) ? {data_byte, 16'h0000} : {buf_e[15:0], 8'h00};
					job.bytes[0] = b64sc_pkg::enc_char(full_e[23:18]);
					job.bytes[1] = b64sc_pkg::enc_char(full_e[17:12]);
					job.bytes[2] = (cnt_e == 3'd2) ? b64sc_pkg::enc_char(full_e[11:6])
					                               : b64sc_pkg::PAD_CHAR;
					job.bytes[3] = b64sc_pkg::PAD_CHAR;
					n = 3'd4;
				end
			end
		end else begin
			if (!stop_q) begin
				if (code[6]) begin
					nxt_stop = 1'b1;
				end else begin
					dbuf = {buf_q[17:0], code[5:0]};
					if (cnt_q == 2'd3) begin
						job.bytes[0] = dbuf[23:16];
						job.bytes[1] = dbuf[15:8];
						job.bytes[2] = dbuf[7:0];
						n    = 3'd3;
						dbuf = '0;
						dcnt = 2'd0;
					end else begin
						dcnt = cnt_q + 2'd1;
					end
				end
			end
			nxt_buf = dbuf;
			nxt_cnt = dcnt;
			if (last_item && dcnt == 2'd2) begin
				job.bytes[0] = dbuf[11:4];
				n = 3'd1;
			end else if (last_item && dcnt == 2'd3) begin
				job.bytes[0] = dbuf[17:10];
				job.bytes[1] = dbuf[9:2];
				n = 3'd2;
			end
		end
		job.has_data = 1'b1;
		if (last_item && n == 3'd0) begin
			job.bytes    = '0;
			job.has_data = 1'b0;
			n            = 3'd1;
		end
		job.cnt  = n;
		job.last = last_item;
		if (last_item) begin
			nxt_buf  = '0;
			nxt_cnt  = 2'd0;
			nxt_stop = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			cnt_q  <= 2'd0;
			stop_q <= 1'b0;
		end else if (cfg_clear) begin
			buf_q  <= '0;
			cnt_q  <= 2'd0;
			stop_q <= 1'b0;
		end else if (accept) begin
			buf_q  <= nxt_buf;
			cnt_q  <= nxt_cnt;
			stop_q <= nxt_stop;
		end
	end

endmodule

// ----- rtl/core/b64sc_fifo.sv -----
// Short job queue between the front and back ends.
module b64sc_fifo #(
	parameter int unsigned DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64sc_pkg::job_t       push_data,
	input  logic                  pop,
	output b64sc_pkg::job_t       pop_data,
	output b64sc_pkg::fifo_stat_t stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	b64sc_pkg::job_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CntW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/b64sc_back.sv -----
// Back end: unpacks queued jobs into single results behind an output register.
module b64sc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64sc_pkg::job_t       pop_data,
	input  b64sc_pkg::fifo_stat_t q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  has_data,
	output logic                  run_end,
	output logic                  message_end
);

	b64sc_pkg::job_t cur_q;
	logic            cur_valid_q;
	logic [1:0]      idx_q;
	logic            slot_free;
	logic            emit;
	logic            final_res;
	logic            load;

	assign slot_free = !out_valid || !out_stall;
	assign emit      = cur_valid_q && slot_free;
	assign final_res = ({1'b0, idx_q} == (cur_q.cnt - 3'd1));
	assign load      = !cur_valid_q || (emit && final_res);
	assign pop       = load && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		if (emit) begin
			out_byte    <= cur_q.bytes[idx_q];
			has_data    <= cur_q.has_data;
			run_end     <= final_res;
			message_end <= final_res && cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid   <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= !q_stat.empty;
			end
			if (emit) begin
				idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- dv/base64_stream_codec_tb.sv -----
// Self-checking testbench for the streaming Base64 codec, with its own predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ADDR_W = b64sc_pkg::ADDR_W;

	// Register map: the mode register at index 0 and an unused index just above it.
	localparam int unsigned SPARE_INDEX = 1;
	localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * b64sc_pkg::REG_MODE);
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * SPARE_INDEX);

	// Start points of the three letter and digit runs of the alphabet.
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [6:0] NOT_B64 = 7'd64;

	// The first result trails its transfer through the queue and the back-end registers,
	// so the quiet period is ample for an item that produces nothing to finish its work.
	localparam int QUIET_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] value;
		logic has_data;
		logic run_end;
		logic msg_end;
	} codec_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [7:0] data_byte;
	logic last_item;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic has_data;
	logic run_end;
	logic message_end;

	// Predictor state: a private copy of the mode register and the group registers.
	logic cur_mode;
	logic [23:0] grp_buf;
	logic [1:0] grp_cnt;
	logic dec_stop;

	// Results still owed by the block, oldest first.
	codec_result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int live_items = 0;
	int results_seen = 0;
	int msgs_encoded = 0;
	int msgs_decoded = 0;

	base64_stream_codec uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.has_data(has_data),
		.run_end(run_end),
		.message_end(message_end)
	);

	always #10 clk = ~clk;

	// Alphabet character for a six-bit code.
	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		if (v < 6'd26) return CH_UPPER_A + {2'b00, v};
		if (v < 6'd52) return CH_LOWER_A + {2'b00, v} - 8'd26;
		if (v < 6'd62) return CH_ZERO + {2'b00, v} - 8'd52;
		if (v == 6'd62) return b64sc_pkg::PLUS_CHAR;
		return b64sc_pkg::SLASH_CHAR;
	endfunction

	// Six-bit code of a character, or NOT_B64 for padding and anything outside the alphabet.
	function automatic logic [6:0] sym_code(input logic [7:0] c);
		if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25) return 7'(c - CH_UPPER_A);
		if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25) return 7'(c - CH_LOWER_A + 8'd26);
		if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return 7'(c - CH_ZERO + 8'd52);
		if (c == b64sc_pkg::PLUS_CHAR) return 7'd62;
		if (c == b64sc_pkg::SLASH_CHAR) return 7'd63;
		return NOT_B64;
	endfunction

	function automatic codec_result_t data_result(input logic [7:0] v);
		return '{v, 1'b1, 1'b0, 1'b0};
	endfunction

	// Adds one result at the tail of a result queue.
	function automatic void add_result(ref codec_result_t q[$], input codec_result_t r);
		q = {q, r};
	endfunction

	// Adds one byte at the tail of a message.
	function automatic void add_char(ref logic [7:0] q[$], input logic [7:0] c);
		q = {q, c};
	endfunction

	function automatic void clear_groups();
		grp_buf = '0;
		grp_cnt = '0;
		dec_stop = 1'b0;
	endfunction

	// Works out the results of one accepted item and queues them. Returns 0 only
	// for a character that the decoder swallows after it has stopped.
	function automatic bit predict_item(input logic [7:0] b, input logic last);
		codec_result_t run[$];
		logic [2:0] cnt;
		logic [23:0] full;
		logic [6:0] code;
		bit counted;
		int k;
		counted = 1'b1;
		if (cur_mode == b64sc_pkg::MODE_ENCODE) begin
			cnt = {1'b0, grp_cnt} + 3'd1;
			grp_buf = {grp_buf[15:0], b};
			if (cnt == 3'd3) begin
				for (k = 0; k < 4; k++)
					add_result(run, data_result(b64_symbol(grp_buf[18 - 6 * k +: 6])));
				grp_buf = '0;
				cnt = 3'd0;
			end
			grp_cnt = cnt[1:0];
			// A partial group is flushed as cnt+1 characters and then padding.
			if (last && cnt != 3'd0) begin
				full = grp_buf << (8 * (3 - cnt));
				for (k = 0; k <= cnt; k++)
					add_result(run, data_result(b64_symbol(full[18 - 6 * k +: 6])));
				for (k = cnt; k < 3; k++)
					add_result(run, data_result(b64sc_pkg::PAD_CHAR));
			end
		end else begin
			if (dec_stop) begin
				counted = !last ? 1'b0 : 1'b1;
			end else begin
				code = sym_code(b);
				if (code == NOT_B64) begin
					dec_stop = 1'b1;
				end else begin
					cnt = {1'b0, grp_cnt} + 3'd1;
					grp_buf = {grp_buf[17:0], code[5:0]};
					if (cnt == 3'd4) begin
						for (k = 0; k < 3; k++)
							add_result(run, data_result(grp_buf[16 - 8 * k +: 8]));
						grp_buf = '0;
						cnt = 3'd0;
					end
					grp_cnt = cnt[1:0];
				end
			end
			// The group held so far, stopped or not, yields one byte fewer than its characters.
			if (last && grp_cnt > 2'd1) begin
				full = grp_buf << (6 * (4 - grp_cnt));
				for (k = 0; k < grp_cnt - 1; k++)
					add_result(run, data_result(full[16 - 8 * k +: 8]));
			end
		end
		// A last item that produced no data still closes the message with a bare marker.
		if (last && run.size() == 0)
			add_result(run, '{8'h00, 1'b0, 1'b0, 1'b0});
		if (run.size() > 0) begin
			run[run.size() - 1].run_end = 1'b1;
			if (last)
				run[run.size() - 1].msg_end = 1'b1;
		end
		if (last)
			clear_groups();
		foreach (run[i])
			add_result(pending_results, run[i]);
		return counted;
	endfunction

	task automatic note_failure(input string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Compares one result transfer with the oldest outstanding expectation.
	task automatic check_result();
		codec_result_t got;
		codec_result_t want;
		got = '{out_byte, has_data, run_end, message_end};
		results_seen++;
		if (pending_results.size() == 0) begin
			note_failure($sformatf("unexpected result: out_byte %02h has_data %0b run_end %0b message_end %0b",
				got.value, got.has_data, got.run_end, got.msg_end));
		end else begin
			want = pending_results.pop_front();
			if (got.value !== want.value || got.has_data !== want.has_data ||
					got.run_end !== want.run_end || got.msg_end !== want.msg_end) begin
				note_failure($sformatf({"result mismatch: expected %02h/%0b/%0b/%0b, ",
					"got %02h/%0b/%0b/%0b (out_byte/has_data/run_end/message_end)"},
					want.value, want.has_data, want.run_end, want.msg_end,
					got.value, got.has_data, got.run_end, got.msg_end));
			end
		end
	endtask

	// Result side: a transfer takes place at an edge where out_valid is high and
	// out_stall is low; the stall for the next cycle is chosen at the same edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// Offers one item, idling beforehand at random, and predicts it once it has
	// been taken. Valid is left high so that a following item streams straight on.
	task automatic send_item(input logic [7:0] b, input logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_item <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (predict_item(b, last))
			live_items++;
		if (last) begin
			if (cur_mode == b64sc_pkg::MODE_ENCODE) msgs_encoded++;
			else msgs_decoded++;
		end
	endtask

	// Setup and access phase, followed by a return to idle on the bus.
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		// Only the mode register exists; writing it also throws away any half-built group.
		if (addr == MODE_ADDR) begin
			cur_mode = data[0];
			clear_groups();
		end
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_mode_readback();
		logic [31:0] rd;
		apb_read(MODE_ADDR, rd);
		if (rd !== {31'b0, cur_mode})
			note_failure($sformatf("mode read back %08h, expected %08h", rd, {31'b0, cur_mode}));
	endtask

	// Stops offering items and waits until every owed result has arrived, then
	// lets the pipeline settle so that a register write finds the block idle.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		foreach (msg[i])
			send_item(msg[i], i == msg.size() - 1);
	endtask

	// Register port: both mode values, the bit that matters at either word extreme,
	// and a write to an unused index that must leave the mode alone.
	task automatic test_register_port();
		check_mode_readback();
		apb_write(MODE_ADDR, 32'h0000_0001);
		check_mode_readback();
		apb_write(MODE_ADDR, 32'hFFFF_FFFE);
		check_mode_readback();
		apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
		check_mode_readback();
		apb_write(MODE_ADDR, 32'hFFFF_FFFF);
		check_mode_readback();
		apb_write(MODE_ADDR, {31'b0, b64sc_pkg::MODE_ENCODE});
		check_mode_readback();
	endtask

	// Encoder: one and two leftover bytes (two and one pad characters), and a
	// message ending on a whole group, which needs no padding at all.
	task automatic test_encode_groups();
		apb_write(MODE_ADDR, {31'b0, b64sc_pkg::MODE_ENCODE});
		send_message('{8'h00});
		send_message('{8'hFF, 8'h80});
		send_message('{8'hFC, 8'h03, 8'hF0});
		wait_quiet();
	endtask

	// Decoder: a full group of the two symbol characters and extreme codes followed
	// by a lone leftover (end marker only), a padded tail, a message that is a
	// single stray byte, and a three-character tail giving two bytes.
	task automatic test_decode_groups();
		apb_write(MODE_ADDR, {31'b0, b64sc_pkg::MODE_DECODE});
		send_message('{b64sc_pkg::PLUS_CHAR, b64sc_pkg::SLASH_CHAR, 8'h39, 8'h7A, 8'h61});
		send_message('{8'h54, 8'h51, b64sc_pkg::PAD_CHAR, b64sc_pkg::PAD_CHAR});
		send_message('{8'hFF});
		send_message('{8'h54, 8'h57, 8'h45});
		wait_quiet();
	endtask

	// A mode write in the middle of a message drops the held group and the stop
	// flag; a write to the unused index does not.
	task automatic test_mode_write_abort();
		send_item(8'h54, 1'b0);
		send_item(8'h57, 1'b0);
		wait_quiet();
		apb_write(MODE_ADDR, {31'b0, b64sc_pkg::MODE_ENCODE});
		send_item(8'h4D, 1'b1);
		send_item(8'h4D, 1'b0);
		wait_quiet();
		apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
		send_item(8'h61, 1'b1);
		wait_quiet();
		apb_write(MODE_ADDR, {31'b0, b64sc_pkg::MODE_DECODE});
		send_item(b64sc_pkg::PAD_CHAR, 1'b0);
		wait_quiet();
		apb_write(MODE_ADDR, {31'b0, b64sc_pkg::MODE_DECODE});
		send_message('{8'h51, 8'h51});
		wait_quiet();
	endtask

	// Random messages under one idling pattern. Decoding is mostly well-formed
	// text, sometimes padded and sometimes with characters after the padding; the
	// rest carries a stray byte or is pure noise. Now and then a message is left
	// open, and between some messages the mode is rewritten with random word data.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int quota);
		logic [7:0] msg[$];
		logic [31:0] word;
		int start;
		int len;
		int kind;
		bit left_open;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = live_items;
		while (live_items - start < quota) begin
			if ($urandom_range(3) == 0) begin
				wait_quiet();
				if ($urandom_range(7) == 0)
					apb_write(SPARE_ADDR, $urandom());
				word = $urandom();
				apb_write(MODE_ADDR, word);
				if ($urandom_range(3) == 0)
					check_mode_readback();
			end
			msg.delete();
			len = ($urandom_range(7) == 0) ? $urandom_range(24, 13) : $urandom_range(9, 1);
			if (cur_mode == b64sc_pkg::MODE_ENCODE) begin
				repeat (len) add_char(msg, 8'($urandom_range(255)));
			end else begin
				kind = $urandom_range(9);
				repeat (len)
					add_char(msg, kind == 9 ? 8'($urandom_range(255))
						: b64_symbol(6'($urandom_range(63))));
				if (kind == 7 || kind == 8) begin
					msg[$urandom_range(len - 1)] = 8'($urandom_range(255));
				end else if (kind < 7 && len % 4 >= 2 && $urandom_range(1) == 1) begin
					while (msg.size() % 4 != 0)
						add_char(msg, b64sc_pkg::PAD_CHAR);
					if ($urandom_range(3) == 0)
						add_char(msg, b64_symbol(6'($urandom_range(63))));
				end
			end
			left_open = ($urandom_range(15) == 0);
			foreach (msg[i])
				send_item(msg[i], !left_open && i == msg.size() - 1);
		end
		wait_quiet();
	endtask

	initial begin
		int waited;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		last_item <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'h0;
		arst_n <= 1'b0;
		cur_mode = b64sc_pkg::MODE_ENCODE;
		clear_groups();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_port();
		test_encode_groups();
		test_decode_groups();
		test_mode_write_abort();
		// Sender idles lightly while the receiver stalls heavily, then the reverse,
		// then full rate on both sides.
		test_random_traffic(15, 53, 118);
		test_random_traffic(53, 15, 118);
		test_random_traffic(0, 0, 118);

		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (QUIET_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("ERROR: %0d expected results never arrived", pending_results.size());
			err_count += pending_results.size();
		end

		$display("Covered %0d items in %0d encoded and %0d decoded messages, %0d results checked.",
			live_items, msgs_encoded, msgs_decoded, results_seen);
		$display("Idling patterns: sender-light/receiver-heavy, the reverse, and none; %0d failures.",
			err_count);
		if (err_count == 0) begin
			$display("base64_stream_codec verification clean");
		end else begin
			$display("base64_stream_codec verification failed");
		end
		$finish;
	end

	// Watchdog: far longer than the slowest correct run needs.
	initial begin
		#2_000_000;
		$display("Timed out waiting for the codec.");
		$display("base64_stream_codec verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/b64sc_pkg.sv
rtl/core/b64sc_front.sv
rtl/core/b64sc_fifo.sv
rtl/core/b64sc_back.sv
rtl/core/base64_stream_codec.sv
dv/base64_stream_codec_tb.sv
